// ----- design/modbus_tcp_request_framer_defines.svh -----
// assertion macros for the modbus/tcp request framer
`ifndef MODBUS_TCP_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_TCP_REQUEST_FRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MTRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mtrf check failed");

// next-cycle implication, checked out of reset
`define MTRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mtrf check failed");

`endif

// ----- design/mtrf_pkg.sv -----
// shared types and constants of the modbus/tcp request framer
`default_nettype none

package mtrf_pkg;

    localparam int FRAME_MAX = 13;
    localparam int NB_W      = 4;
    localparam int QDEPTH    = 2;
    localparam int PTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W     = $clog2(QDEPTH + 1);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [7:0] FC_READ_COILS  = 8'd1;
    localparam logic [7:0] FC_READ_INPUTS = 8'd2;
    localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FC_WRITE_REG   = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

    localparam logic [15:0] COIL_LIMIT     = 16'd2040;
    localparam logic [15:0] COIL_ON        = 16'hFF00;
    localparam logic [15:0] LEN_SHORT      = 16'd6;
    localparam logic [15:0] LEN_MULTI_BASE = 16'd7;
    localparam logic [7:0]  UNIT_ID_RESET  = 8'd1;
    localparam logic [15:0] TID_RESET      = 16'd1;

    localparam logic [NB_W-1:0] NB_SHORT  = NB_W'(12);
    localparam logic [NB_W-1:0] NB_MULTI  = NB_W'(13);
    localparam logic [NB_W-1:0] NB_ONE    = NB_W'(1);
    localparam logic [NB_W-1:0] NB_TWO    = NB_W'(2);

    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] frame_bytes;
        logic [NB_W-1:0]           num_bytes;
        logic                      last_flag;
        logic                      status;
    } job_t;

endpackage

`default_nettype wire

// ----- design/modbus_tcp_request_framer.sv -----
// the first byte of an item's result passes through the job queue, then the output register
// throughput: one byte per cycle from the back end while m_ready is high; a start item gives
// 12 or 13 bytes (1 when rejected), a register data item 2, a coil data item 1 per packed byte
// the two-entry job queue lets the front take items while the back end serializes
// reset: unit id 1, transaction id 1, no write open, queue and output empty
`default_nettype none

`include "modbus_tcp_request_framer_defines.svh"

module modbus_tcp_request_framer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_cmd,
    input  wire logic [7:0]   s_function_code,
    input  wire logic [15:0]  s_address,
    input  wire logic [15:0]  s_quantity,
    input  wire logic [15:0]  s_value,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_last,
    output logic              m_status
);

    logic           s_accept;
    logic           job_valid;
    mtrf_pkg::job_t job;
    mtrf_pkg::job_t head;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;
    assign q_push   = s_accept && job_valid;

    mtrf_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_accept        (s_accept),
        .s_cmd           (s_cmd),
        .s_function_code (s_function_code),
        .s_address       (s_address),
        .s_quantity      (s_quantity),
        .s_value         (s_value),
        .job_valid       (job_valid),
        .job             (job)
    );

    mtrf_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (job),
        .pop     (q_pop),
        .rd_data (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    mtrf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .m_status   (m_status)
    );

    `MTRF_ASSERT_NOW(a_reject_form, m_valid && m_status, m_last && (m_out_byte == 8'd0))
    `MTRF_ASSERT_NOW(a_no_pop_empty, q_pop, !q_empty)
    `MTRF_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_empty)

endmodule

`default_nettype wire

// ----- design/mtrf_front.sv -----
// front end: accepts items, tracks open writes and builds byte jobs
`default_nettype none

module mtrf_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [7:0]    cfg_wr_data,
    input  wire logic          s_accept,
    input  wire logic          s_cmd,
    input  wire logic [7:0]    s_function_code,
    input  wire logic [15:0]   s_address,
    input  wire logic [15:0]   s_quantity,
    input  wire logic [15:0]   s_value,
    output logic               job_valid,
    output mtrf_pkg::job_t     job
);

    typedef enum logic [1:0] {
        OPEN_NONE  = 2'd0,
        OPEN_REGS  = 2'd1,
        OPEN_COILS = 2'd2
    } open_kind_t;

    open_kind_t  open_kind_reg, open_kind_next;
    logic [15:0] tid_reg, tid_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  coil_acc_reg, coil_acc_next;
    logic [2:0]  coil_pos_reg, coil_pos_next;
    logic [7:0]  unit_id_reg;

    logic        is_multi;
    logic        is_reject;
    logic [16:0] q_plus7;
    logic [15:0] byte_cnt;
    logic [15:0] len;
    logic [15:0] word;
    logic [15:0] rem_dec;
    logic [7:0]  acc_new;

    always_comb begin
        is_multi  = (s_function_code == mtrf_pkg::FC_WRITE_COILS) ||
                    (s_function_code == mtrf_pkg::FC_WRITE_REGS);
        is_reject = ((s_function_code == mtrf_pkg::FC_READ_COILS) ||
                     (s_function_code == mtrf_pkg::FC_READ_INPUTS)) &&
                    (s_quantity > mtrf_pkg::COIL_LIMIT);
        q_plus7   = {1'b0, s_quantity} + 17'd7;
        byte_cnt  = (s_function_code == mtrf_pkg::FC_WRITE_REGS) ?
                    {s_quantity[14:0], 1'b0} : {2'b00, q_plus7[16:3]};
        rem_dec   = remaining_reg - 16'd1;
        acc_new   = coil_acc_reg | (8'(s_value[0]) << coil_pos_reg);

        if (s_function_code == mtrf_pkg::FC_WRITE_COIL) begin
            word = s_value[0] ? mtrf_pkg::COIL_ON : 16'd0;
            len  = mtrf_pkg::LEN_SHORT;
        end else if (s_function_code == mtrf_pkg::FC_WRITE_REG) begin
            word = s_value;
            len  = mtrf_pkg::LEN_SHORT;
        end else if (is_multi) begin
            word = s_quantity;
            len  = mtrf_pkg::LEN_MULTI_BASE + byte_cnt;
        end else begin
            word = s_quantity;
            len  = mtrf_pkg::LEN_SHORT;
        end

        job            = '0;
        job_valid      = 1'b0;
        open_kind_next = open_kind_reg;
        tid_next       = tid_reg;
        remaining_next = remaining_reg;
        coil_acc_next  = coil_acc_reg;
        coil_pos_next  = coil_pos_reg;

        if (s_cmd == mtrf_pkg::CMD_START) begin
            open_kind_next = OPEN_NONE;
            remaining_next = 16'd0;
            coil_acc_next  = 8'd0;
            coil_pos_next  = 3'd0;
            job_valid      = 1'b1;
            if (is_reject) begin
                job.num_bytes = mtrf_pkg::NB_ONE;
                job.last_flag = 1'b1;
                job.status    = 1'b1;
            end else begin
                tid_next            = tid_reg + 16'd1;
                job.frame_bytes[0]  = tid_reg[15:8];
                job.frame_bytes[1]  = tid_reg[7:0];
                job.frame_bytes[4]  = len[15:8];
                job.frame_bytes[5]  = len[7:0];
                job.frame_bytes[6]  = unit_id_reg;
                job.frame_bytes[7]  = s_function_code;
                job.frame_bytes[8]  = s_address[15:8];
                job.frame_bytes[9]  = s_address[7:0];
                job.frame_bytes[10] = word[15:8];
                job.frame_bytes[11] = word[7:0];
                job.frame_bytes[12] = byte_cnt[7:0];
                job.num_bytes       = is_multi ? mtrf_pkg::NB_MULTI : mtrf_pkg::NB_SHORT;
                job.last_flag       = !(is_multi && (s_quantity != 16'd0));
                if (is_multi && (s_quantity != 16'd0)) begin
                    open_kind_next = (s_function_code == mtrf_pkg::FC_WRITE_REGS) ?
                                     OPEN_REGS : OPEN_COILS;
                    remaining_next = s_quantity;
                end
            end
        end else if ((open_kind_reg != OPEN_NONE) && (remaining_reg != 16'd0)) begin
            remaining_next = rem_dec;
            if (open_kind_reg == OPEN_REGS) begin
                job_valid          = 1'b1;
                job.frame_bytes[0] = s_value[15:8];
                job.frame_bytes[1] = s_value[7:0];
                job.num_bytes      = mtrf_pkg::NB_TWO;
                job.last_flag      = (rem_dec == 16'd0);
            end else if ((coil_pos_reg == 3'd7) || (rem_dec == 16'd0)) begin
                job_valid          = 1'b1;
                job.frame_bytes[0] = acc_new;
                job.num_bytes      = mtrf_pkg::NB_ONE;
                job.last_flag      = (rem_dec == 16'd0);
                coil_acc_next      = 8'd0;
                coil_pos_next      = 3'd0;
            end else begin
                coil_acc_next = acc_new;
                coil_pos_next = coil_pos_reg + 3'd1;
            end
            if (rem_dec == 16'd0) begin
                open_kind_next = OPEN_NONE;
                coil_acc_next  = 8'd0;
                coil_pos_next  = 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_kind_reg <= OPEN_NONE;
            tid_reg       <= mtrf_pkg::TID_RESET;
            remaining_reg <= 16'd0;
            coil_acc_reg  <= 8'd0;
            coil_pos_reg  <= 3'd0;
            unit_id_reg   <= mtrf_pkg::UNIT_ID_RESET;
        end else begin
            if (cfg_wr_en) begin
                unit_id_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                open_kind_reg <= open_kind_next;
                tid_reg       <= tid_next;
                remaining_reg <= remaining_next;
                coil_acc_reg  <= coil_acc_next;
                coil_pos_reg  <= coil_pos_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/mtrf_fifo.sv -----
// small job queue between front and back end
`default_nettype none

module mtrf_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire mtrf_pkg::job_t wr_data,
    input  wire logic           pop,
    output mtrf_pkg::job_t      rd_data,
    output logic                full,
    output logic                empty
);

    mtrf_pkg::job_t                   mem [mtrf_pkg::QDEPTH];
    logic [mtrf_pkg::PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [mtrf_pkg::CNT_W-1:0]       count_reg;

    localparam logic [mtrf_pkg::PTR_W-1:0] PTR_LAST = mtrf_pkg::PTR_W'(mtrf_pkg::QDEPTH - 1);
    localparam logic [mtrf_pkg::PTR_W-1:0] PTR_ONE  = mtrf_pkg::PTR_W'(1);
    localparam logic [mtrf_pkg::CNT_W-1:0] CNT_FULL = mtrf_pkg::CNT_W'(mtrf_pkg::QDEPTH);
    localparam logic [mtrf_pkg::CNT_W-1:0] CNT_ONE  = mtrf_pkg::CNT_W'(1);

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_ONE;
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_ONE;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/mtrf_back.sv -----
// back end: serializes queued jobs into registered output bytes
`default_nettype none

module mtrf_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire mtrf_pkg::job_t head,
    input  wire logic           q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_last,
    output logic                m_status
);

    mtrf_pkg::job_t         cur_reg, cur_next;
    logic                   active_reg, active_next;
    logic [mtrf_pkg::NB_W-1:0] idx_reg, idx_next;
    logic                   m_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   last_reg;
    logic                   status_reg;

    mtrf_pkg::job_t         src;
    logic [mtrf_pkg::NB_W-1:0] src_idx;
    logic                   src_ok;
    logic                   advance;
    logic                   final_byte;

    always_comb begin
        src        = active_reg ? cur_reg : head;
        src_idx    = active_reg ? idx_reg : '0;
        src_ok     = active_reg || !q_empty;
        advance    = !m_valid_reg || m_ready;
        final_byte = (src_idx == (src.num_bytes - mtrf_pkg::NB_ONE));

        q_pop       = 1'b0;
        cur_next    = cur_reg;
        active_next = active_reg;
        idx_next    = idx_reg;
        if (advance && src_ok) begin
            if (active_reg) begin
                if (final_byte) begin
                    active_next = 1'b0;
                end else begin
                    idx_next = idx_reg + mtrf_pkg::NB_ONE;
                end
            end else begin
                q_pop = 1'b1;
                if (!final_byte) begin
                    cur_next    = head;
                    idx_next    = mtrf_pkg::NB_ONE;
                    active_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            if (advance) begin
                m_valid_reg <= src_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        if (advance) begin
            out_byte_reg <= src.frame_bytes[src_idx];
            last_reg     <= final_byte && src.last_flag;
            status_reg   <= src.status;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = last_reg;
    assign m_status   = status_reg;

endmodule

`default_nettype wire

// ----- tb/sv/mtrf_frame_checker.sv -----
// byte stream predictor and checker for the modbus/tcp request framer
`timescale 1ns / 100ps

module mtrf_frame_checker
    import mtrf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_cmd,
    input  wire logic [7:0]  s_function_code,
    input  wire logic [15:0] s_address,
    input  wire logic [15:0] s_quantity,
    input  wire logic [15:0] s_value,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_out_byte,
    input  wire logic        m_last,
    input  wire logic        m_status,
    output int               mismatches,
    output int               bytes_owed
);

    typedef enum logic [1:0] {
        OPEN_NONE,
        OPEN_REGS,
        OPEN_COILS
    } open_write_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       reject;
    } frame_byte_t;

    frame_byte_t bytes_due[$];

    logic [7:0]  unit_id;
    logic [15:0] trans_id;
    open_write_e open_write;
    logic [15:0] elements_left;
    logic [7:0]  coil_pack;
    logic [2:0]  coil_pos;

    function automatic void owe(input logic [7:0] data, input logic last,
                                input logic reject);
        frame_byte_t fb;
        fb.data   = data;
        fb.last   = last;
        fb.reject = reject;
        bytes_due.push_back(fb);
    endfunction

    function automatic void frame_item(input logic cmd, input logic [7:0] fc,
                                       input logic [15:0] addr, input logic [15:0] qty,
                                       input logic [15:0] val);
        logic [7:0]  hdr [13];
        logic [31:0] len;
        logic [31:0] cnt;
        logic [15:0] word;
        int          nbytes;
        if (cmd == CMD_START) begin
            open_write    = OPEN_NONE;
            elements_left = '0;
            coil_pack     = '0;
            coil_pos      = '0;
            if ((fc == FC_READ_COILS || fc == FC_READ_INPUTS) && qty > COIL_LIMIT) begin
                owe(8'h00, 1'b1, 1'b1);
            end else begin
                nbytes = 12;
                word   = qty;
                len    = 32'(LEN_SHORT);
                cnt    = '0;
                if (fc == FC_WRITE_COIL) begin
                    word = val[0] ? COIL_ON : 16'h0000;
                end else if (fc == FC_WRITE_REG) begin
                    word = val;
                end else if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
                    cnt     = (fc == FC_WRITE_REGS) ? 32'(qty) * 2 : (32'(qty) + 7) >> 3;
                    len     = 32'(LEN_MULTI_BASE) + cnt;
                    hdr[12] = cnt[7:0];
                    nbytes  = 13;
                    if (qty != 0) begin
                        open_write    = (fc == FC_WRITE_REGS) ? OPEN_REGS : OPEN_COILS;
                        elements_left = qty;
                    end
                end
                hdr[0]  = trans_id[15:8];
                hdr[1]  = trans_id[7:0];
                hdr[2]  = 8'h00;
                hdr[3]  = 8'h00;
                hdr[4]  = len[15:8];
                hdr[5]  = len[7:0];
                hdr[6]  = unit_id;
                hdr[7]  = fc;
                hdr[8]  = addr[15:8];
                hdr[9]  = addr[7:0];
                hdr[10] = word[15:8];
                hdr[11] = word[7:0];
                for (int i = 0; i < nbytes; i++)
                    owe(hdr[i], (i == nbytes - 1) && open_write == OPEN_NONE, 1'b0);
                trans_id = trans_id + 16'd1;
            end
        end else if (open_write != OPEN_NONE && elements_left != 0) begin
            elements_left = elements_left - 16'd1;
            if (open_write == OPEN_REGS) begin
                owe(val[15:8], 1'b0, 1'b0);
                owe(val[7:0], elements_left == 0, 1'b0);
            end else begin
                coil_pack = coil_pack | (8'(val[0]) << coil_pos);
                if (coil_pos == 3'd7 || elements_left == 0) begin
                    owe(coil_pack, elements_left == 0, 1'b0);
                    coil_pack = '0;
                    coil_pos  = '0;
                end else begin
                    coil_pos = coil_pos + 3'd1;
                end
            end
            if (elements_left == 0) begin
                open_write = OPEN_NONE;
                coil_pack  = '0;
                coil_pos   = '0;
            end
        end
    endfunction

    always @(posedge aclk) begin
        frame_byte_t want;
        if (!aresetn) begin
            bytes_due.delete();
            unit_id       = UNIT_ID_RESET;
            trans_id      = TID_RESET;
            open_write    = OPEN_NONE;
            elements_left = '0;
            coil_pack     = '0;
            coil_pos      = '0;
            mismatches    = 0;
        end else begin
            if (cfg_wr_en)
                unit_id = cfg_wr_data;
            if (s_valid && s_ready)
                frame_item(s_cmd, s_function_code, s_address, s_quantity, s_value);
            if (m_valid && m_ready) begin
                if (bytes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: item expected none actual byte %02h last %0b status %0b",
                             $time, m_out_byte, m_last, m_status);
                end else begin
                    want = bytes_due.pop_front();
                    if (m_out_byte !== want.data) begin
                        mismatches++;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.data, m_out_byte);
                    end
                    if (m_last !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %0b actual %0b", $time, want.last, m_last);
                    end
                    if (m_status !== want.reject) begin
                        mismatches++;
                        $display("%0t: status expected %0b actual %0b",
                                 $time, want.reject, m_status);
                    end
                end
            end
        end
        bytes_owed <= bytes_due.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench top for the modbus/tcp request framer: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
    import mtrf_pkg::*;

    localparam int RUN_LIMIT     = 200_000;
    localparam int SETTLE_CYCLES = 16;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic [7:0]  cfg_wr_data     = 8'h00;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_cmd           = CMD_START;
    logic [7:0]  s_function_code = 8'h00;
    logic [15:0] s_address       = 16'h0000;
    logic [15:0] s_quantity      = 16'h0000;
    logic [15:0] s_value         = 16'h0000;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;
    logic        m_status;

    int mismatches;
    int bytes_owed;
    int cycle_count = 0;
    int rx_wait     = 0;
    bit tx_burst    = 1'b0;
    bit rx_burst    = 1'b0;

    modbus_tcp_request_framer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_function_code (s_function_code),
        .s_address       (s_address),
        .s_quantity      (s_quantity),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last          (m_last),
        .m_status        (m_status)
    );

    mtrf_frame_checker frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_function_code (s_function_code),
        .s_address       (s_address),
        .s_quantity      (s_quantity),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last          (m_last),
        .m_status        (m_status),
        .mismatches      (mismatches),
        .bytes_owed      (bytes_owed)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // per-byte receiver stall, with bursts of back-to-back acceptance
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 5);
        end else if (rx_wait > 0) begin
            rx_wait--;
        end
        m_ready <= aresetn && rx_wait == 0;
    end

    task automatic send_item(input logic cmd, input logic [7:0] fc, input logic [15:0] addr,
                             input logic [15:0] qty, input logic [15:0] val);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_function_code <= fc;
        s_address       <= addr;
        s_quantity      <= qty;
        s_value         <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic settle;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bytes_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_unit(input logic [7:0] id);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic write_multi(input logic [7:0] fc, input logic [15:0] qty, input int elements);
        send_item(CMD_START, fc, 16'($urandom_range(0, 65535)), qty,
                  16'($urandom_range(0, 65535)));
        for (int i = 0; i < elements; i++)
            send_item(CMD_DATA, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic random_traffic(input int n_items);
        int         sent;
        int         pick;
        int         qty;
        int         elems;
        logic [7:0] fc;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                fc    = $urandom_range(0, 1) ? FC_WRITE_REGS : FC_WRITE_COILS;
                qty   = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 64)
                                                    : $urandom_range(0, 20);
                elems = qty;
                // cut short, or trailed by stray data once closed
                if ($urandom_range(0, 5) == 0)
                    elems = $urandom_range(0, qty);
                else if ($urandom_range(0, 7) == 0)
                    elems = qty + $urandom_range(1, 3);
                write_multi(fc, 16'(qty), elems);
                sent += 1 + elems;
            end else if (pick <= 7) begin
                if ($urandom_range(0, 1))
                    fc = $urandom_range(0, 1) ? FC_READ_COILS : FC_READ_INPUTS;
                else
                    fc = 8'($urandom_range(0, 255));
                qty = $urandom_range(0, 1) ? $urandom_range(0, COIL_LIMIT + 8)
                                           : $urandom_range(0, 65535);
                send_item(CMD_START, fc, 16'($urandom_range(0, 65535)), 16'(qty),
                          16'($urandom_range(0, 65535)));
                sent++;
            end else if (pick == 8) begin
                send_item(CMD_START, $urandom_range(0, 1) ? FC_WRITE_COIL : FC_WRITE_REG,
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)));
                sent++;
            end else begin
                send_item(CMD_DATA, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                sent++;
            end
        end
    endtask

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes, quantity limit, single writes
        send_item(CMD_START, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_START, FC_READ_COILS, 16'hFFFF, COIL_LIMIT, 16'h0000);
        send_item(CMD_START, FC_READ_INPUTS, 16'h1234, COIL_LIMIT + 16'd1, 16'h0000);
        send_item(CMD_START, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_START, FC_WRITE_COIL, 16'h0000, 16'h0000, 16'h0001);
        send_item(CMD_START, FC_WRITE_COIL, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        send_item(CMD_START, FC_WRITE_REG, 16'h0000, 16'h0000, 16'hFFFF);
        // multi writes, empty write, stray data, abandon while open, wide length
        send_item(CMD_START, FC_WRITE_REGS, 16'h0100, 16'd2, 16'h0000);
        send_item(CMD_DATA, 8'h00, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(CMD_DATA, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        write_multi(FC_WRITE_COILS, 16'd9, 9);
        send_item(CMD_START, FC_WRITE_COILS, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_DATA, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_START, FC_WRITE_REGS, 16'h0000, 16'hFFFF, 16'h0000);
        send_item(CMD_DATA, 8'h00, 16'h0000, 16'h0000, 16'hA5C3);
        send_item(CMD_START, FC_WRITE_COILS, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_DATA, 8'h00, 16'h0000, 16'h0000, 16'h0001);
        send_item(CMD_START, FC_READ_COILS, 16'h0000, 16'hFFFF, 16'h0000);

        settle;
        set_unit(8'h00);
        random_traffic(30);
        settle;
        set_unit(8'hFF);
        random_traffic(30);
        settle;
        set_unit(8'($urandom_range(0, 255)));
        random_traffic(30);
        settle;

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
